@@ rtl/tcca_pkg.sv @@
// shared types, constants and sizes of the touch calibration and averaging block
package tcca_pkg;

	// screen geometry and averaging window
	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 240;
	localparam int AVERAGE_DEPTH = 4;

	// field widths
	localparam int WORD_W = 15;
	localparam int RAW_W  = 12;
	localparam int RAW_LSB = 3;
	localparam int PT_W   = 16;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 12;

	localparam logic [RAW_W-1:0] MIN_X_RST  = RAW_W'(1000);
	localparam logic [RAW_W-1:0] MIN_Y_RST  = RAW_W'(1000);
	localparam logic [RAW_W-1:0] MAX_X_RST  = RAW_W'(3200);
	localparam logic [RAW_W-1:0] MAX_Y_RST  = RAW_W'(2000);
	localparam logic             INV_X_RST  = 1'b1;
	localparam logic             INV_Y_RST  = 1'b1;
	localparam logic             SWAP_RST   = 1'b0;

	// derived sizes
	localparam int SIZE_MAX  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int SIZE_W    = $clog2(SIZE_MAX + 1);
	localparam int PROD_W    = RAW_W + SIZE_W;
	localparam int CNT_W     = $clog2(AVERAGE_DEPTH + 1);
	localparam int IDX_W     = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
	localparam int SUM_W     = PT_W + $clog2(AVERAGE_DEPTH);
	localparam int DVS_W     = (RAW_W > CNT_W) ? RAW_W : CNT_W;
	localparam int DIV_RAW_W = (PROD_W > SUM_W) ? PROD_W : SUM_W;
	localparam int DIV_W     = DIV_RAW_W + (DIV_RAW_W % 2);
	localparam int DIV_STEPS = DIV_W / 2;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_X,
		REG_MIN_Y,
		REG_MAX_X,
		REG_MAX_Y,
		REG_INV_X,
		REG_INV_Y,
		REG_SWAP
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CDIV,
		ST_PUSH,
		ST_SUM,
		ST_ADIV,
		ST_FIN
	} seq_state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/tcca_in_if.sv @@
// input channel: one panel poll per transfer
interface tcca_in_if;
	logic                             valid;
	logic                             ready;
	logic                             pen_down;
	logic [tcca_pkg::WORD_W-1:0]      raw_word_x;
	logic [tcca_pkg::WORD_W-1:0]      raw_word_y;

	modport source(output valid, pen_down, raw_word_x, raw_word_y, input ready);
	modport sink(input valid, pen_down, raw_word_x, raw_word_y, output ready);
endinterface

@@ rtl/tcca_out_if.sv @@
// output channel: one screen point per transfer
interface tcca_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [tcca_pkg::PT_W-1:0] point_x;
	logic signed [tcca_pkg::PT_W-1:0] point_y;
	logic                             pressed;

	modport source(output valid, point_x, point_y, pressed, input ready);
	modport sink(input valid, point_x, point_y, pressed, output ready);
endinterface

@@ rtl/touch_coordinate_calibrate_average_top.sv @@
// top level: touch point calibration, scaling and moving average
//
// samples (sink) takes one panel poll per transfer: pen_down and two converter
// words whose 12-bit value sits in bits 14..3. points (source) returns exactly
// one point per poll: point_x, point_y and pressed.
// A pen-down poll runs the calibration divide and the averaging divide for x,
// then for y, on one shared two-bit-per-cycle divider. The average is taken
// over the last 1 to AVERAGE_DEPTH samples, and samples is not ready until
// the point is done.
// An axis whose span is zero or negative skips its calibration divide.
// A pen-up poll repeats the held point with pressed low in the cycle after its
// transfer, clears the sample count and leaves the history in place.
// A finished point waits in the result register until points takes it; until
// then samples is not ready, and a pen-down point that finishes behind it
// waits in its last step.
// The cfg port writes one register per cycle with cfg_we high; unknown
// indexes are ignored. Reset clears the count, the held point and the
// handshake state and restores the register defaults.
module touch_coordinate_calibrate_average_top (
	input  logic                             clk,
	input  logic                             arst_n,
	tcca_in_if.sink                          samples,
	tcca_out_if.source                       points,
	input  logic                             cfg_we,
	input  logic [tcca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tcca_pkg::CFG_W-1:0]       cfg_data
);

	localparam int PT_W  = tcca_pkg::PT_W;
	localparam int RAW_W = tcca_pkg::RAW_W;

	// configuration
	logic [RAW_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
	logic             inv_x_q, inv_y_q, swap_q;

	// sequencer and state
	tcca_pkg::seq_state_t               state_q, state_d;
	logic                               axis_q;
	logic [tcca_pkg::CNT_W-1:0]         cnt_q;
	logic [tcca_pkg::CNT_W-1:0]         sum_cnt_q;
	logic signed [PT_W-1:0]             held_x_q, held_y_q;
	logic signed [PT_W-1:0]             hist_x_q [tcca_pkg::AVERAGE_DEPTH];
	logic signed [PT_W-1:0]             hist_y_q [tcca_pkg::AVERAGE_DEPTH];

	// working registers
	logic [RAW_W-1:0]                   rx_q, ry_q;
	logic                               span_ok_q;
	logic signed [PT_W-1:0]             cal_q;
	logic signed [tcca_pkg::SUM_W-1:0]  sum_q;
	logic                               neg_q;

	// result register
	logic                               out_v_q;
	logic signed [PT_W-1:0]             out_x_q, out_y_q;
	logic                               out_p_q;

	tcca_pkg::div_req_t                 div_req;
	tcca_pkg::div_rsp_t                 div_rsp;

	logic                               out_free;
	logic                               acc;
	logic [RAW_W-1:0]                   raw_x_in, raw_y_in;
	logic [RAW_W-1:0]                   sel_raw, sel_lo, sel_hi;
	logic [tcca_pkg::SIZE_W-1:0]        sel_size;
	logic                               sel_inv;
	logic [RAW_W-1:0]                   off;
	logic                               span_ok;
	logic [RAW_W-1:0]                   span;
	logic [tcca_pkg::PROD_W-1:0]        prod;
	logic [PT_W-1:0]                    cal_base;
	logic signed [PT_W-1:0]             cal_val;
	logic signed [PT_W-1:0]             hist_sel;
	logic [tcca_pkg::SUM_W-1:0]         sum_mag;
	logic [PT_W-1:0]                    quot_lo;
	logic signed [PT_W-1:0]             avg_val;
	logic                               sum_last;

	tcca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign out_free      = !out_v_q || points.ready;
	assign samples.ready = (state_q == tcca_pkg::ST_IDLE) && out_free;
	assign acc           = samples.valid && samples.ready;

	assign raw_x_in = samples.raw_word_x[tcca_pkg::RAW_LSB +: RAW_W];
	assign raw_y_in = samples.raw_word_y[tcca_pkg::RAW_LSB +: RAW_W];

	// per-axis operand selection for the shared datapath
	always_comb begin
		sel_raw  = axis_q ? ry_q : rx_q;
		sel_lo   = axis_q ? min_y_q : min_x_q;
		sel_hi   = axis_q ? max_y_q : max_x_q;
		sel_inv  = axis_q ? inv_y_q : inv_x_q;
		sel_size = axis_q ? tcca_pkg::SIZE_W'(tcca_pkg::SCREEN_HEIGHT)
		                  : tcca_pkg::SIZE_W'(tcca_pkg::SCREEN_WIDTH);
		off      = (sel_raw > sel_lo) ? (sel_raw - sel_lo) : '0;
		span_ok  = sel_hi > sel_lo;
		span     = sel_hi - sel_lo;
		prod     = tcca_pkg::PROD_W'(off) * tcca_pkg::PROD_W'(sel_size);
		cal_base = span_ok_q ? div_rsp.quotient[PT_W-1:0] : '0;
		cal_val  = sel_inv ? (PT_W'(sel_size) - cal_base) : cal_base;
		hist_sel = axis_q ? hist_y_q[sum_cnt_q[tcca_pkg::IDX_W-1:0]]
		                  : hist_x_q[sum_cnt_q[tcca_pkg::IDX_W-1:0]];
		// magnitude of the signed sum, the most negative sum reads correctly unsigned
		sum_mag  = sum_q[tcca_pkg::SUM_W-1] ? ({tcca_pkg::SUM_W{1'b0}} - sum_q) : sum_q;
		quot_lo  = div_rsp.quotient[PT_W-1:0];
		avg_val  = neg_q ? ({PT_W{1'b0}} - quot_lo) : quot_lo;
		sum_last = sum_cnt_q == cnt_q;
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		case (state_q)
			tcca_pkg::ST_IDLE: begin
				if (acc && samples.pen_down) state_d = tcca_pkg::ST_MUL;
			end
			tcca_pkg::ST_MUL: begin
				div_req.start    = span_ok;
				div_req.dividend = tcca_pkg::DIV_W'(prod);
				div_req.divisor  = tcca_pkg::DVS_W'(span);
				state_d          = tcca_pkg::ST_CDIV;
			end
			tcca_pkg::ST_CDIV: begin
				if (!span_ok_q || div_rsp.done) state_d = tcca_pkg::ST_PUSH;
			end
			tcca_pkg::ST_PUSH: begin
				state_d = tcca_pkg::ST_SUM;
			end
			tcca_pkg::ST_SUM: begin
				if (sum_last) begin
					div_req.start    = 1'b1;
					div_req.dividend = tcca_pkg::DIV_W'(sum_mag);
					div_req.divisor  = tcca_pkg::DVS_W'(cnt_q);
					state_d          = tcca_pkg::ST_ADIV;
				end
			end
			tcca_pkg::ST_ADIV: begin
				if (div_rsp.done) state_d = axis_q ? tcca_pkg::ST_FIN : tcca_pkg::ST_MUL;
			end
			tcca_pkg::ST_FIN: begin
				if (out_free) state_d = tcca_pkg::ST_IDLE;
			end
			default: begin
				state_d = tcca_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tcca_pkg::ST_IDLE;
			axis_q    <= 1'b0;
			cnt_q     <= '0;
			sum_cnt_q <= '0;
			held_x_q  <= '0;
			held_y_q  <= '0;
			out_v_q   <= 1'b0;
			min_x_q   <= tcca_pkg::MIN_X_RST;
			min_y_q   <= tcca_pkg::MIN_Y_RST;
			max_x_q   <= tcca_pkg::MAX_X_RST;
			max_y_q   <= tcca_pkg::MAX_Y_RST;
			inv_x_q   <= tcca_pkg::INV_X_RST;
			inv_y_q   <= tcca_pkg::INV_Y_RST;
			swap_q    <= tcca_pkg::SWAP_RST;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (tcca_pkg::cfg_reg_t'(cfg_index))
					tcca_pkg::REG_MIN_X: min_x_q <= cfg_data[RAW_W-1:0];
					tcca_pkg::REG_MIN_Y: min_y_q <= cfg_data[RAW_W-1:0];
					tcca_pkg::REG_MAX_X: max_x_q <= cfg_data[RAW_W-1:0];
					tcca_pkg::REG_MAX_Y: max_y_q <= cfg_data[RAW_W-1:0];
					tcca_pkg::REG_INV_X: inv_x_q <= cfg_data[0];
					tcca_pkg::REG_INV_Y: inv_y_q <= cfg_data[0];
					tcca_pkg::REG_SWAP:  swap_q  <= cfg_data[0];
					default: ;
				endcase
			end

			if (acc) begin
				axis_q <= 1'b0;
				if (!samples.pen_down) begin
					cnt_q <= '0;
				end else if (cnt_q < tcca_pkg::CNT_W'(tcca_pkg::AVERAGE_DEPTH)) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end

			if (state_q == tcca_pkg::ST_PUSH) begin
				sum_cnt_q <= '0;
			end else if (state_q == tcca_pkg::ST_SUM && !sum_last) begin
				sum_cnt_q <= sum_cnt_q + 1'b1;
			end

			if (state_q == tcca_pkg::ST_ADIV && div_rsp.done) begin
				if (axis_q) begin
					held_y_q <= avg_val;
				end else begin
					held_x_q <= avg_val;
					axis_q   <= 1'b1;
				end
			end

			if (acc && !samples.pen_down) begin
				out_v_q <= 1'b1;
			end else if (state_q == tcca_pkg::ST_FIN && out_free) begin
				out_v_q <= 1'b1;
			end else if (points.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rx_q <= swap_q ? raw_y_in : raw_x_in;
			ry_q <= swap_q ? raw_x_in : raw_y_in;
		end

		if (state_q == tcca_pkg::ST_MUL) span_ok_q <= span_ok;

		if (state_q == tcca_pkg::ST_CDIV) cal_q <= cal_val;

		if (state_q == tcca_pkg::ST_PUSH) begin
			sum_q <= '0;
			for (int i = tcca_pkg::AVERAGE_DEPTH - 1; i > 0; i--) begin
				if (axis_q) hist_y_q[i] <= hist_y_q[i-1];
				else        hist_x_q[i] <= hist_x_q[i-1];
			end
			if (axis_q) hist_y_q[0] <= cal_q;
			else        hist_x_q[0] <= cal_q;
		end

		if (state_q == tcca_pkg::ST_SUM) begin
			if (!sum_last) sum_q <= sum_q + tcca_pkg::SUM_W'(hist_sel);
			else           neg_q <= sum_q[tcca_pkg::SUM_W-1];
		end

		if (acc && !samples.pen_down) begin
			out_x_q <= held_x_q;
			out_y_q <= held_y_q;
			out_p_q <= 1'b0;
		end else if (state_q == tcca_pkg::ST_FIN && out_free) begin
			out_x_q <= held_x_q;
			out_y_q <= held_y_q;
			out_p_q <= 1'b1;
		end
	end

	assign points.valid   = out_v_q;
	assign points.point_x = out_x_q;
	assign points.point_y = out_y_q;
	assign points.pressed = out_p_q;

endmodule

@@ rtl/tcca_div.sv @@
// shared unsigned restoring divider, two quotient bits per cycle
module tcca_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tcca_pkg::div_req_t req,
	output tcca_pkg::div_rsp_t rsp
);

	logic [tcca_pkg::DIV_W-1:0]  q_q;
	logic [tcca_pkg::DVS_W-1:0]  r_q;
	logic [tcca_pkg::DVS_W-1:0]  d_q;
	logic [tcca_pkg::STEP_W-1:0] steps_q;
	logic                        run_q;
	logic                        done_q;

	logic [tcca_pkg::DVS_W:0]    r_a;
	logic [tcca_pkg::DVS_W:0]    r_b;
	logic [tcca_pkg::DVS_W:0]    r_a_sub;
	logic [tcca_pkg::DVS_W:0]    r_b_sub;
	logic                        ge_a;
	logic                        ge_b;
	logic [tcca_pkg::DVS_W-1:0]  r_mid;
	logic [tcca_pkg::DVS_W-1:0]  r_next;

	always_comb begin
		r_a     = {r_q, q_q[tcca_pkg::DIV_W-1]};
		ge_a    = r_a >= {1'b0, d_q};
		r_a_sub = r_a - {1'b0, d_q};
		r_mid   = ge_a ? r_a_sub[tcca_pkg::DVS_W-1:0] : r_a[tcca_pkg::DVS_W-1:0];
		r_b     = {r_mid, q_q[tcca_pkg::DIV_W-2]};
		ge_b    = r_b >= {1'b0, d_q};
		r_b_sub = r_b - {1'b0, d_q};
		r_next  = ge_b ? r_b_sub[tcca_pkg::DVS_W-1:0] : r_b[tcca_pkg::DVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q   <= 1'b1;
				steps_q <= tcca_pkg::STEP_W'(tcca_pkg::DIV_STEPS);
			end else if (run_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == tcca_pkg::STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q <= req.dividend;
			r_q <= '0;
			d_q <= req.divisor;
		end else if (run_q) begin
			q_q <= {q_q[tcca_pkg::DIV_W-3:0], ge_a, ge_b};
			r_q <= r_next;
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = q_q;

endmodule

@@ rtl/tcca_chk.sv @@
// port-level checks for the touch calibration block, bound to the top level
module tcca_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         pen_down,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [tcca_pkg::PT_W-1:0]    point_x,
	input logic                         pressed
);

	// a stalled point stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("point dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(point_x))
		else $error("point changed while stalled");

	// a released poll is answered in the next cycle
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !pen_down |=> out_valid && !pressed)
		else $error("released poll not answered next cycle");

	// a pressed poll occupies the divider, no new transfer meanwhile
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && pen_down |=> !in_ready)
		else $error("new poll taken while busy");

endmodule

bind touch_coordinate_calibrate_average_top tcca_chk u_tcca_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.pen_down  (samples.pen_down),
	.out_valid (points.valid),
	.out_ready (points.ready),
	.point_x   (points.point_x),
	.pressed   (points.pressed)
);
